FILE: rtl/core/eat_pkg.sv
// shared constants and types for the entity archetype table
package eat_pkg;

	localparam int ENTITY_COUNT_DEF       = 256;
	localparam int COMPONENT_TYPES_DEF    = 8;
	localparam int ARCHETYPE_SLOTS_DEF    = 32;
	localparam int ARCHETYPE_CAPACITY_DEF = 256;
	localparam int MAX_REPORT             = 32;
	localparam int KW                     = $clog2(MAX_REPORT + 1);

	localparam int OPW  = 3;
	localparam int IDW  = 8;
	localparam int CMPW = 3;
	localparam int MSKW = 8;
	localparam int AIW  = 5;
	localparam int ASGW = 8;
	localparam int AMW  = 9;
	localparam int STW  = 3;

	typedef logic [OPW-1:0] opcode_t;
	typedef logic [STW-1:0] status_t;

	localparam opcode_t OP_CREATE  = 3'd0;
	localparam opcode_t OP_DESTROY = 3'd1;
	localparam opcode_t OP_ADD     = 3'd2;
	localparam opcode_t OP_REMOVE  = 3'd3;
	localparam opcode_t OP_QUERY   = 3'd4;

	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_EMPTY      = 3'd1;
	localparam status_t ST_OVERFLOW   = 3'd2;
	localparam status_t ST_TABLE_FULL = 3'd3;
	localparam status_t ST_LIST_FULL  = 3'd4;

	typedef enum logic [16:0] {
		S_INIT   = 17'h00001,
		S_IDLE   = 17'h00002,
		S_POP    = 17'h00004,
		S_SIG    = 17'h00008,
		S_DSIG   = 17'h00010,
		S_DNXT   = 17'h00020,
		S_UNF    = 17'h00040,
		S_FR     = 17'h00080,
		S_FC     = 17'h00100,
		S_MR     = 17'h00200,
		S_MC     = 17'h00400,
		S_MMV    = 17'h00800,
		S_SETSIG = 17'h01000,
		S_CDONE  = 17'h02000,
		S_QR     = 17'h04000,
		S_QC     = 17'h08000,
		S_OUT    = 17'h10000
	} state_t;

endpackage

FILE: rtl/core/eat_ram.sv
// generic single-port-write ram with registered read
module eat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/entity_archetype_table.sv
// entity archetype table top level
//
// Entity manager. One item on the input channel (opcode, entity, component,
// query_mask) is create, destroy, add component, remove component or query.
// Every item but a query gives exactly one result item with last set; a
// query gives one result per matching archetype in table order (at most 32),
// the final one with last set, or a single not-found item.
// One item is worked at a time. Add and remove compare archetype entries in
// turn to find the old and the new archetype and scan the old member list;
// destroy repeats that for each component bit the entity holds. Query
// compares each archetype entry in turn. The sequencer works on four
// memories with one write port and a registered read port each (free ID
// stack, entity signatures, archetype table, member lists). After reset a
// sweep loads the free ID stack and clears the signatures; in_ready stays
// low until it is done. A result waits in the output register while
// out_ready is low; the sequencer holds only when a further result is due,
// and it can take a new item while the old result still waits.
module entity_archetype_table #(
	parameter int ENTITY_COUNT       = eat_pkg::ENTITY_COUNT_DEF,
	parameter int COMPONENT_TYPES    = eat_pkg::COMPONENT_TYPES_DEF,
	parameter int ARCHETYPE_SLOTS    = eat_pkg::ARCHETYPE_SLOTS_DEF,
	parameter int ARCHETYPE_CAPACITY = eat_pkg::ARCHETYPE_CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [eat_pkg::OPW-1:0]  opcode,
	input  logic [eat_pkg::IDW-1:0]  entity,
	input  logic [eat_pkg::CMPW-1:0] component,
	input  logic [eat_pkg::MSKW-1:0] query_mask,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [eat_pkg::IDW-1:0]  entity_id,
	output logic [eat_pkg::AIW-1:0]  archetype_index,
	output logic [eat_pkg::ASGW-1:0] archetype_signature,
	output logic [eat_pkg::AMW-1:0]  archetype_members,
	output logic                     found,
	output logic [eat_pkg::STW-1:0]  status,
	output logic                     last
);
	import eat_pkg::*;

	localparam int EW  = $clog2(ENTITY_COUNT);
	localparam int CT  = COMPONENT_TYPES;
	localparam int TW  = (CT > 1) ? $clog2(CT) : 1;
	localparam int AW  = (ARCHETYPE_SLOTS > 1) ? $clog2(ARCHETYPE_SLOTS) : 1;
	localparam int SZW = $clog2(ARCHETYPE_CAPACITY + 1);
	localparam int MD  = ARCHETYPE_SLOTS * ARCHETYPE_CAPACITY;
	localparam int MW  = (MD > 1) ? $clog2(MD) : 1;
	localparam int ARW = CT + SZW;

	state_t state_q, ret_q;

	logic [EW-1:0]   ini_q;
	logic [EW:0]     cnt_q;
	logic [AW:0]     used_q;
	logic [AW:0]     a_q;
	logic [KW-1:0]   k_q;
	logic [TW:0]     i_q;
	logic [SZW-1:0]  n_q, j_q;
	logic            phase_q;
	opcode_t         op_q;
	logic [EW-1:0]   e_q;
	logic [TW-1:0]   t_q;
	logic [MSKW-1:0] mask_q;
	logic [CT-1:0]   sig_q, nsig_q;
	status_t         st_q, fst_q;

	logic [AW-1:0]   hi_q;
	logic [CT-1:0]   hs_q;
	logic [SZW-1:0]  hm_q;

	logic [IDW-1:0]  r_id_q;
	logic [AIW-1:0]  r_idx_q;
	logic [ASGW-1:0] r_sig_q;
	logic [AMW-1:0]  r_mem_q;
	logic            r_found_q, r_last_q;
	status_t         r_status_q;

	logic            ov_q;
	logic [IDW-1:0]  o_id_q;
	logic [AIW-1:0]  o_idx_q;
	logic [ASGW-1:0] o_sig_q;
	logic [AMW-1:0]  o_mem_q;
	logic            o_found_q, o_last_q;
	status_t         o_status_q;

	logic            f_we;
	logic [EW-1:0]   f_waddr, f_wdata, f_raddr, f_rdata;
	logic            s_we;
	logic [EW-1:0]   s_waddr, s_raddr;
	logic [CT-1:0]   s_wdata, s_rdata;
	logic            a_we;
	logic [AW-1:0]   a_waddr, a_raddr;
	logic [ARW-1:0]  a_wdata, a_rdata;
	logic            m_we;
	logic [MW-1:0]   m_waddr, m_raddr, m_base;
	logic [EW-1:0]   m_wdata, m_rdata;

	logic            acc, e_ok, t_ok, a_miss, a_hit, cap_full, q_match;
	logic [CT-1:0]   rd_sig, target;
	logic [SZW-1:0]  rd_size;

	eat_ram #(.WIDTH(EW), .DEPTH(ENTITY_COUNT)) u_free (
		.clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
	);
	eat_ram #(.WIDTH(CT), .DEPTH(ENTITY_COUNT)) u_esig (
		.clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
	);
	eat_ram #(.WIDTH(ARW), .DEPTH(ARCHETYPE_SLOTS)) u_arch (
		.clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_rdata)
	);
	eat_ram #(.WIDTH(EW), .DEPTH(MD)) u_memb (
		.clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
	);

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;
	assign e_ok     = 32'(entity) < 32'(ENTITY_COUNT);
	assign t_ok     = 32'(component) < 32'(CT);
	assign rd_sig   = a_rdata[ARW-1:SZW];
	assign rd_size  = a_rdata[SZW-1:0];
	assign target   = phase_q ? nsig_q : sig_q;
	assign a_miss   = a_q >= used_q;
	assign a_hit    = rd_sig == target;
	assign cap_full = 32'(rd_size) >= 32'(ARCHETYPE_CAPACITY);
	assign q_match  = (32'(rd_sig) & 32'(mask_q)) == 32'(mask_q);
	assign m_base   = MW'(32'(a_q[AW-1:0]) * 32'(ARCHETYPE_CAPACITY));

	always_comb begin
		f_we    = 1'b0;
		f_waddr = cnt_q[EW-1:0];
		f_wdata = EW'(entity);
		f_raddr = EW'(cnt_q - 1'b1);
		s_we    = 1'b0;
		s_waddr = e_q;
		s_wdata = nsig_q;
		s_raddr = EW'(entity);
		a_we    = 1'b0;
		a_waddr = a_q[AW-1:0];
		a_wdata = {nsig_q, SZW'(rd_size + 1'b1)};
		a_raddr = a_q[AW-1:0];
		m_we    = 1'b0;
		m_waddr = m_base + MW'(rd_size);
		m_wdata = e_q;
		m_raddr = m_base + MW'(j_q);
		case (state_q)
			S_INIT: begin
				f_we    = 1'b1;
				f_waddr = ini_q;
				f_wdata = EW'(ENTITY_COUNT - 1) - ini_q;
				s_we    = 1'b1;
				s_waddr = ini_q;
				s_wdata = '0;
			end
			S_IDLE: begin
				f_we = acc && opcode == OP_DESTROY && 32'(cnt_q) < 32'(ENTITY_COUNT) && e_ok;
			end
			S_FR: begin
				if (phase_q && a_miss && 32'(used_q) < 32'(ARCHETYPE_SLOTS)) begin
					a_we    = 1'b1;
					a_wdata = {nsig_q, SZW'(1)};
					m_we    = 1'b1;
					m_waddr = m_base;
				end
			end
			S_FC: begin
				if (phase_q && a_hit && !cap_full) begin
					a_we = 1'b1;
					m_we = 1'b1;
				end
			end
			S_MC: begin
				m_raddr = m_base + MW'(n_q - 1'b1);
			end
			S_MMV: begin
				a_we    = 1'b1;
				a_wdata = {sig_q, SZW'(n_q - 1'b1)};
				m_we    = 1'b1;
				m_waddr = m_base + MW'(j_q);
				m_wdata = m_rdata;
			end
			S_SETSIG: begin
				s_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ret_q   <= S_IDLE;
			ini_q   <= '0;
			cnt_q   <= (EW+1)'(ENTITY_COUNT);
			used_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (out_ready && state_q != S_OUT) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					ini_q <= ini_q + 1'b1;
					if (32'(ini_q) == ENTITY_COUNT - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						op_q       <= opcode;
						e_q        <= EW'(entity);
						t_q        <= TW'(component);
						mask_q     <= query_mask;
						r_id_q     <= '0;
						r_idx_q    <= '0;
						r_sig_q    <= '0;
						r_mem_q    <= '0;
						r_found_q  <= 1'b0;
						r_last_q   <= 1'b1;
						r_status_q <= ST_OK;
						ret_q      <= S_IDLE;
						phase_q    <= 1'b0;
						a_q        <= '0;
						k_q        <= '0;
						state_q    <= S_OUT;
						case (opcode)
							OP_CREATE: begin
								if (cnt_q == '0) begin
									r_status_q <= ST_EMPTY;
								end else begin
									state_q <= S_POP;
								end
							end
							OP_DESTROY: begin
								if (32'(cnt_q) >= 32'(ENTITY_COUNT)) begin
									r_status_q <= ST_OVERFLOW;
								end else if (e_ok) begin
									cnt_q   <= cnt_q + 1'b1;
									state_q <= S_DSIG;
								end
							end
							OP_ADD, OP_REMOVE: begin
								if (e_ok && t_ok) begin
									state_q <= S_SIG;
								end
							end
							OP_QUERY: begin
								state_q <= S_QR;
							end
							default: begin
							end
						endcase
					end
				end
				S_POP: begin
					r_id_q  <= IDW'(f_rdata);
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_OUT;
				end
				S_SIG: begin
					sig_q <= s_rdata;
					if (op_q == OP_ADD) begin
						nsig_q <= s_rdata | (CT'(1) << t_q);
					end else begin
						nsig_q <= s_rdata & ~(CT'(1) << t_q);
					end
					state_q <= S_UNF;
				end
				S_DSIG: begin
					sig_q   <= s_rdata;
					i_q     <= '0;
					st_q    <= ST_OK;
					state_q <= S_DNXT;
				end
				S_DNXT: begin
					if (32'(i_q) == CT) begin
						r_status_q <= st_q;
						state_q    <= S_OUT;
					end else begin
						i_q <= i_q + 1'b1;
						if (sig_q[i_q[TW-1:0]]) begin
							nsig_q  <= sig_q & ~(CT'(1) << i_q[TW-1:0]);
							phase_q <= 1'b0;
							state_q <= S_UNF;
						end
					end
				end
				S_UNF: begin
					a_q <= '0;
					if (sig_q == '0) begin
						state_q <= S_SETSIG;
					end else begin
						state_q <= S_FR;
					end
				end
				S_FR: begin
					if (a_miss) begin
						if (!phase_q) begin
							state_q <= S_SETSIG;
						end else begin
							if (32'(used_q) >= 32'(ARCHETYPE_SLOTS)) begin
								fst_q <= ST_TABLE_FULL;
							end else begin
								fst_q  <= ST_OK;
								used_q <= used_q + 1'b1;
							end
							state_q <= S_CDONE;
						end
					end else begin
						state_q <= S_FC;
					end
				end
				S_FC: begin
					if (a_hit) begin
						if (!phase_q) begin
							n_q     <= rd_size;
							j_q     <= '0;
							state_q <= S_MR;
						end else begin
							fst_q   <= cap_full ? ST_LIST_FULL : ST_OK;
							state_q <= S_CDONE;
						end
					end else begin
						a_q     <= a_q + 1'b1;
						state_q <= S_FR;
					end
				end
				S_MR: begin
					state_q <= (j_q >= n_q) ? S_SETSIG : S_MC;
				end
				S_MC: begin
					if (m_rdata == e_q) begin
						state_q <= S_MMV;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_MR;
					end
				end
				S_MMV: begin
					state_q <= S_SETSIG;
				end
				S_SETSIG: begin
					a_q <= '0;
					if (nsig_q == '0) begin
						fst_q   <= ST_OK;
						state_q <= S_CDONE;
					end else begin
						phase_q <= 1'b1;
						state_q <= S_FR;
					end
				end
				S_CDONE: begin
					sig_q <= nsig_q;
					if (op_q == OP_DESTROY) begin
						if (st_q == ST_OK) begin
							st_q <= fst_q;
						end
						state_q <= S_DNXT;
					end else begin
						r_status_q <= fst_q;
						state_q    <= S_OUT;
					end
				end
				S_QR: begin
					if (a_miss || 32'(k_q) >= MAX_REPORT) begin
						if (k_q != '0) begin
							r_idx_q   <= AIW'(hi_q);
							r_sig_q   <= ASGW'(hs_q);
							r_mem_q   <= AMW'(hm_q);
							r_found_q <= 1'b1;
						end
						r_last_q <= 1'b1;
						ret_q    <= S_IDLE;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_QC;
					end
				end
				S_QC: begin
					a_q     <= a_q + 1'b1;
					state_q <= S_QR;
					if (q_match) begin
						if (k_q != '0) begin
							r_idx_q   <= AIW'(hi_q);
							r_sig_q   <= ASGW'(hs_q);
							r_mem_q   <= AMW'(hm_q);
							r_found_q <= 1'b1;
							r_last_q  <= 1'b0;
							ret_q     <= S_QR;
							state_q   <= S_OUT;
						end
						hi_q <= a_q[AW-1:0];
						hs_q <= rd_sig;
						hm_q <= rd_size;
						k_q  <= k_q + 1'b1;
					end
				end
				S_OUT: begin
					if (!ov_q || out_ready) begin
						ov_q    <= 1'b1;
						state_q <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!ov_q || out_ready)) begin
			o_id_q     <= r_id_q;
			o_idx_q    <= r_idx_q;
			o_sig_q    <= r_sig_q;
			o_mem_q    <= r_mem_q;
			o_found_q  <= r_found_q;
			o_last_q   <= r_last_q;
			o_status_q <= r_status_q;
		end
	end

	assign out_valid           = ov_q;
	assign entity_id           = o_id_q;
	assign archetype_index     = o_idx_q;
	assign archetype_signature = o_sig_q;
	assign archetype_members   = o_mem_q;
	assign found               = o_found_q;
	assign status              = o_status_q;
	assign last                = o_last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= ENTITY_COUNT)
		else $error("free stack count beyond entity count");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= ARCHETYPE_SLOTS)
		else $error("archetype count beyond table size");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new item taken while one is in work");

	a_report_limit: assert property (@(posedge clk) disable iff (!arst_n)
		32'(k_q) <= MAX_REPORT)
		else $error("query reported too many archetypes");
endmodule
